// File: rtl/cst_pkg.sv
package cst_pkg;

  localparam int VALUE_BITS = 32;
  localparam int POS_BITS   = 16;
  localparam int ACC_BITS   = VALUE_BITS + 4;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_NUMBER,
    MODE_COMMENT,
    MODE_DONE
  } mode_t;

  typedef enum logic [3:0] {
    KIND_INTEGER = 4'd0,
    KIND_PLUS    = 4'd1,
    KIND_MINUS   = 4'd2,
    KIND_STAR    = 4'd3,
    KIND_SLASH   = 4'd4,
    KIND_LPAREN  = 4'd5,
    KIND_RPAREN  = 4'd6,
    KIND_DOT     = 4'd7,
    KIND_SEMI    = 4'd8,
    KIND_COLON   = 4'd9,
    KIND_COMMA   = 4'd10,
    KIND_END     = 4'd11
  } kind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    kind_t                 kind;
    logic [VALUE_BITS-1:0] value;
    logic                  sat;
    logic [POS_BITS-1:0]   line;
    logic [POS_BITS-1:0]   col;
  } token_t;

  // results of one byte: tok0 always valid, tok1 only when two is set
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_DOT:    k = KIND_DOT;
      CH_SEMI:   k = KIND_SEMI;
      CH_COLON:  k = KIND_COLON;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/cst_front.sv
module cst_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      char_code,
  output logic            push,
  output cst_pkg::entry_t push_entry
);
  import cst_pkg::*;

  mode_t                 mode_r, mode_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  sat_r, sat_nxt;
  logic [POS_BITS-1:0]   line_r, line_nxt;
  logic [POS_BITS-1:0]   col_r, col_nxt;

  logic                  is_dig, is_sp;
  logic [POS_BITS-1:0]   line_inc, col_inc, cnt_line, cnt_col;
  logic [ACC_BITS-1:0]   acc_wide;
  logic                  acc_over;
  logic                  emit_int, emit_oth, oth_cnt;
  kind_t                 oth_kind;
  token_t                int_tok, oth_tok;

  assign is_dig = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_sp  = (char_code == CH_SPACE) || (char_code == CH_TAB) || (char_code == CH_NL) ||
                  (char_code == CH_VT) || (char_code == CH_FF) || (char_code == CH_CR);

  // position after counting this byte, both counters clamp at all ones
  assign line_inc = (line_r == '1) ? line_r : line_r + 1'b1;
  assign col_inc  = (col_r == '1) ? col_r : col_r + 1'b1;
  assign cnt_line = (char_code == CH_NL) ? line_inc : line_r;
  assign cnt_col  = (char_code == CH_NL) ? POS_BITS'(1) : col_inc;

  // acc*10 + digit, overflow past the value width means clamp
  assign acc_wide = ({{(ACC_BITS-VALUE_BITS){1'b0}}, acc_r} << 3) +
                    ({{(ACC_BITS-VALUE_BITS){1'b0}}, acc_r} << 1) +
                    ACC_BITS'(char_code[3:0]);
  assign acc_over = |acc_wide[ACC_BITS-1:VALUE_BITS];

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    emit_int = 1'b0;
    emit_oth = 1'b0;
    oth_cnt  = 1'b0;
    oth_kind = KIND_END;
    unique case (mode_r)
      MODE_DONE: begin
      end
      MODE_COMMENT: begin
        if (char_code == CH_NUL) begin
          emit_oth = 1'b1;
          mode_nxt = MODE_DONE;
        end else begin
          line_nxt = cnt_line;
          col_nxt  = cnt_col;
          if (char_code == CH_RBRACE) mode_nxt = MODE_NORMAL;
        end
      end
      MODE_NORMAL, MODE_NUMBER: begin
        if (mode_r == MODE_NUMBER && is_dig) begin
          line_nxt = cnt_line;
          col_nxt  = cnt_col;
          acc_nxt  = acc_over ? '1 : acc_wide[VALUE_BITS-1:0];
          sat_nxt  = sat_r | acc_over;
        end else begin
          if (mode_r == MODE_NUMBER) begin
            // digit run ends here, the byte itself is handled as usual
            emit_int = 1'b1;
            acc_nxt  = '0;
            sat_nxt  = 1'b0;
            mode_nxt = MODE_NORMAL;
          end
          priority if (char_code == CH_NUL) begin
            emit_oth = 1'b1;
            mode_nxt = MODE_DONE;
          end else if (is_sp) begin
            line_nxt = cnt_line;
            col_nxt  = cnt_col;
          end else if (char_code == CH_LBRACE) begin
            line_nxt = cnt_line;
            col_nxt  = cnt_col;
            mode_nxt = MODE_COMMENT;
          end else if (is_dig) begin
            line_nxt = cnt_line;
            col_nxt  = cnt_col;
            acc_nxt  = VALUE_BITS'(char_code[3:0]);
            sat_nxt  = 1'b0;
            mode_nxt = MODE_NUMBER;
          end else begin
            line_nxt = cnt_line;
            col_nxt  = cnt_col;
            emit_oth = 1'b1;
            oth_cnt  = 1'b1;
            oth_kind = punct_kind(char_code);
            if (oth_kind == KIND_END) mode_nxt = MODE_DONE;
          end
        end
      end
    endcase
  end

  always_comb begin
    int_tok.kind  = KIND_INTEGER;
    int_tok.value = acc_r;
    int_tok.sat   = sat_r;
    int_tok.line  = line_r;
    int_tok.col   = col_r;

    oth_tok.kind  = oth_kind;
    oth_tok.value = '0;
    oth_tok.sat   = 1'b0;
    oth_tok.line  = oth_cnt ? cnt_line : line_r;
    oth_tok.col   = oth_cnt ? cnt_col : col_r;

    if (emit_int) begin
      push_entry.two  = emit_oth;
      push_entry.tok0 = int_tok;
      push_entry.tok1 = oth_tok;
    end else begin
      push_entry.two  = 1'b0;
      push_entry.tok0 = oth_tok;
      push_entry.tok1 = oth_tok;
    end
  end

  assign push = accept && (emit_int || emit_oth);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= '0;
      sat_r  <= 1'b0;
      line_r <= '0;
      col_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      sat_r  <= sat_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

// File: rtl/cst_queue.sv
module cst_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cst_pkg::entry_t push_entry,
  input  logic            pop,
  output cst_pkg::entry_t head,
  output logic            empty,
  output logic            full
);
  import cst_pkg::*;

  entry_t                mem_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_CNT_BITS-1:0] cnt_r, cnt_nxt;

  assign head  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == Q_CNT_BITS'(Q_DEPTH));

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

// File: rtl/cst_back.sv
module cst_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cst_pkg::entry_t                head,
  input  logic                           empty,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cst_pkg::kind_t                 out_token_kind,
  output logic [cst_pkg::VALUE_BITS-1:0] out_number_value,
  output logic                           out_number_saturated,
  output logic [cst_pkg::POS_BITS-1:0]   out_line_number,
  output logic [cst_pkg::POS_BITS-1:0]   out_column_number,
  output logic                           out_last_of_run
);
  import cst_pkg::*;

  logic   valid_r, valid_nxt;
  logic   sub_r, sub_nxt;
  token_t tok_r, tok_nxt;
  logic   last_r, last_nxt;
  logic   load, sel_last;
  token_t sel_tok;

  // second token of a pair goes out after the first one
  assign sel_tok  = sub_r ? head.tok1 : head.tok0;
  assign sel_last = sub_r || !head.two;
  assign load     = !empty && (!valid_r || !out_stall);
  assign pop      = load && sel_last;

  always_comb begin
    valid_nxt = valid_r;
    sub_nxt   = sub_r;
    tok_nxt   = tok_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      sub_nxt   = !sel_last;
      tok_nxt   = sel_tok;
      last_nxt  = sel_last;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

  assign out_valid            = valid_r;
  assign out_token_kind       = tok_r.kind;
  assign out_number_value     = tok_r.value;
  assign out_number_saturated = tok_r.sat;
  assign out_line_number      = tok_r.line;
  assign out_column_number    = tok_r.col;
  assign out_last_of_run      = last_r;

endmodule

// File: rtl/char_stream_tokenizer_top.sv
// text tokenizer, one byte per input transfer on in_char_code
// input channel: in_valid / in_stall, a byte is taken when in_valid is high
//   and in_stall low; in_stall rises only when the token queue is full
// output channel: out_valid / out_stall, one token per transfer with kind,
//   value, saturation flag, line and column after its last byte, and
//   out_last_of_run marking the final token caused by one byte
// throughput: one byte per cycle while in_stall is low; a byte that ends a number and
//   is itself a token yields two tokens, which leave one after the other through the
//   output register, so the output port sets the rate for such bytes
// path: a token is written into the queue with the byte that completes it, then moves
//   from the queue head into the output register that drives out_valid
// bytes that give no token (whitespace, comments, digits) push nothing into the queue
// after an end token the block ignores every byte until reset
// reset (rst_n low at a clock edge) clears scan state, counters, the queue
//   and the output register; no clearing pass is needed
// when the receiver stalls, the output token holds and the queue absorbs up
//   to four further token-producing bytes before in_stall goes high; bytes
//   that give no token keep flowing
module char_stream_tokenizer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_char_code,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cst_pkg::kind_t                 out_token_kind,
  output logic [cst_pkg::VALUE_BITS-1:0] out_number_value,
  output logic                           out_number_saturated,
  output logic [cst_pkg::POS_BITS-1:0]   out_line_number,
  output logic [cst_pkg::POS_BITS-1:0]   out_column_number,
  output logic                           out_last_of_run
);
  import cst_pkg::*;

  logic   accept, push, pop, q_empty, q_full;
  entry_t push_entry, head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  cst_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .char_code  (in_char_code),
    .push       (push),
    .push_entry (push_entry)
  );

  cst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  cst_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .empty                (q_empty),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_token_kind       (out_token_kind),
    .out_number_value     (out_number_value),
    .out_number_saturated (out_number_saturated),
    .out_line_number      (out_line_number),
    .out_column_number    (out_column_number),
    .out_last_of_run      (out_last_of_run)
  );

endmodule

// File: rtl/cst_checker.sv
module cst_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input cst_pkg::kind_t                 out_token_kind,
  input logic [cst_pkg::VALUE_BITS-1:0] out_number_value,
  input logic                           out_number_saturated,
  input logic [cst_pkg::POS_BITS-1:0]   out_line_number,
  input logic [cst_pkg::POS_BITS-1:0]   out_column_number,
  input logic                           out_last_of_run
);
  import cst_pkg::*;

  // a stalled token holds until it is transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind) &&
      $stable(out_number_value) && $stable(out_number_saturated) &&
      $stable(out_line_number) && $stable(out_column_number) && $stable(out_last_of_run))
    else $error("stalled output token changed");

  // output register empties on reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // only integer tokens carry a value or a clamp flag
  a_value_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_INTEGER |-> out_number_value == '0 &&
      !out_number_saturated)
    else $error("non-integer token with value");

  // a clamped constant reads as all ones
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_number_saturated |-> out_number_value == '1)
    else $error("saturated value not at maximum");

  // an end token is always the last token of its byte
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_END |-> out_last_of_run)
    else $error("end token not last of run");

endmodule

bind char_stream_tokenizer_top cst_checker u_cst_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_token_kind       (out_token_kind),
  .out_number_value     (out_number_value),
  .out_number_saturated (out_number_saturated),
  .out_line_number      (out_line_number),
  .out_column_number    (out_column_number),
  .out_last_of_run      (out_last_of_run)
);

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int ITEM_TARGET  = 1150;
  localparam int STALL_LIMIT  = 2000;
  localparam int TRAIL_BYTES  = 24;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    token_t tok;
    logic   last;
  } token_rec_t;

  typedef struct packed {
    logic [7:0]            ch;
    logic                  typed;
    kind_t                 kind;
    logic [VALUE_BITS-1:0] value;
    logic                  sat;
  } stim_row_t;

  // ways the text can be closed; only one per run since reset comes once
  typedef enum int {
    CLOSE_NUL,
    CLOSE_IN_COMMENT,
    CLOSE_NUMBER_NUL,
    CLOSE_STRAY,
    CLOSE_NUMBER_STRAY
  } close_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_char_code = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  kind_t                 out_token_kind;
  logic [VALUE_BITS-1:0] out_number_value;
  logic                  out_number_saturated;
  logic [POS_BITS-1:0]   out_line_number;
  logic [POS_BITS-1:0]   out_column_number;
  logic                  out_last_of_run;

  char_stream_tokenizer_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_char_code         (in_char_code),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_token_kind       (out_token_kind),
    .out_number_value     (out_number_value),
    .out_number_saturated (out_number_saturated),
    .out_line_number      (out_line_number),
    .out_column_number    (out_column_number),
    .out_last_of_run      (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner state as the predictor sees it
  mode_t                 scan_state = MODE_NORMAL;
  logic [VALUE_BITS-1:0] digit_acc = '0;
  logic                  digit_clamped = 1'b0;
  logic [POS_BITS-1:0]   line_pos = '0;
  logic [POS_BITS-1:0]   col_pos = '0;

  token_rec_t step_tokens[$];
  token_rec_t expected_tokens[$];

  logic      calm = 1'b0;
  logic      typed_active = 1'b0;
  stim_row_t typed_row;
  int        bytes_fed = 0;
  int        tokens_checked = 0;
  int        fail_count = 0;
  int        quiet_cycles = 0;
  logic [11:0] kinds_seen = '0;

  logic [7:0] punct_chars [10] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN,
                                   CH_RPAREN, CH_DOT, CH_SEMI, CH_COLON, CH_COMMA};
  logic [7:0] space_chars [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
  string boundary_numbers [4] = '{"4294967295", "4294967296",
                                  "0000000000004294967295", "99999999999999999999"};

  stim_row_t opening_rows [24] = '{
    '{CH_PLUS,   1'b1, KIND_PLUS,    32'd0, 1'b0},
    '{CH_MINUS,  1'b1, KIND_MINUS,   32'd0, 1'b0},
    '{CH_STAR,   1'b1, KIND_STAR,    32'd0, 1'b0},
    '{CH_SLASH,  1'b1, KIND_SLASH,   32'd0, 1'b0},
    '{CH_LPAREN, 1'b1, KIND_LPAREN,  32'd0, 1'b0},
    '{CH_RPAREN, 1'b1, KIND_RPAREN,  32'd0, 1'b0},
    '{CH_DOT,    1'b1, KIND_DOT,     32'd0, 1'b0},
    '{CH_SEMI,   1'b1, KIND_SEMI,    32'd0, 1'b0},
    '{CH_COLON,  1'b1, KIND_COLON,   32'd0, 1'b0},
    '{CH_COMMA,  1'b1, KIND_COMMA,   32'd0, 1'b0},
    '{CH_SPACE,  1'b0, KIND_END,     32'd0, 1'b0},
    '{CH_TAB,    1'b0, KIND_END,     32'd0, 1'b0},
    '{CH_NL,     1'b0, KIND_END,     32'd0, 1'b0},
    '{CH_VT,     1'b0, KIND_END,     32'd0, 1'b0},
    '{CH_FF,     1'b0, KIND_END,     32'd0, 1'b0},
    '{CH_CR,     1'b0, KIND_END,     32'd0, 1'b0},
    '{CH_ZERO,   1'b0, KIND_END,     32'd0, 1'b0},
    // brace ends the number and opens a comment
    '{CH_LBRACE, 1'b1, KIND_INTEGER, 32'd0, 1'b0},
    '{8'hFF,     1'b0, KIND_END,     32'd0, 1'b0},
    '{CH_RBRACE, 1'b0, KIND_END,     32'd0, 1'b0},
    '{CH_ZERO + 8'd7, 1'b0, KIND_END, 32'd0, 1'b0},
    // number then punctuation: two tokens from one byte
    '{CH_PLUS,   1'b1, KIND_INTEGER, 32'd7, 1'b0},
    '{CH_NINE,   1'b0, KIND_END,     32'd0, 1'b0},
    '{CH_NL,     1'b1, KIND_INTEGER, 32'd9, 1'b0}
  };

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] ch);
    case (ch)
      CH_PLUS:   return KIND_PLUS;
      CH_MINUS:  return KIND_MINUS;
      CH_STAR:   return KIND_STAR;
      CH_SLASH:  return KIND_SLASH;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_DOT:    return KIND_DOT;
      CH_SEMI:   return KIND_SEMI;
      CH_COLON:  return KIND_COLON;
      CH_COMMA:  return KIND_COMMA;
      default:   return KIND_END;
    endcase
  endfunction

  task automatic advance_position(input logic [7:0] ch);
    if (ch == CH_NL) begin
      if (line_pos != '1) line_pos = line_pos + 1'b1;
      col_pos = POS_BITS'(1);
    end else if (col_pos != '1) begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic emit_token(input kind_t kind, input logic [VALUE_BITS-1:0] value,
                            input logic sat);
    token_rec_t rec;
    rec.tok.kind  = kind;
    rec.tok.value = value;
    rec.tok.sat   = sat;
    rec.tok.line  = line_pos;
    rec.tok.col   = col_pos;
    rec.last      = 1'b0;
    step_tokens.push_back(rec);
  endtask

  // predicts the tokens caused by one byte into step_tokens
  task automatic tokenize_char(input logic [7:0] ch);
    longint unsigned digit;
    longint unsigned wide;
    kind_t kind;
    digit = longint'(ch - CH_ZERO);
    if (scan_state == MODE_DONE) return;
    if (scan_state == MODE_COMMENT) begin
      if (ch == CH_NUL) begin
        emit_token(KIND_END, '0, 1'b0);
        scan_state = MODE_DONE;
      end else begin
        advance_position(ch);
        if (ch == CH_RBRACE) scan_state = MODE_NORMAL;
      end
      return;
    end
    if (scan_state == MODE_NUMBER) begin
      if (is_digit(ch)) begin
        advance_position(ch);
        if ({32'd0, digit_acc} > (64'hFFFF_FFFF - digit) / 10) begin
          digit_acc = '1;
          digit_clamped = 1'b1;
        end else begin
          wide = {32'd0, digit_acc} * 64'd10 + digit;
          digit_acc = wide[VALUE_BITS-1:0];
        end
        return;
      end
      emit_token(KIND_INTEGER, digit_acc, digit_clamped);
      digit_acc = '0;
      digit_clamped = 1'b0;
      scan_state = MODE_NORMAL;
    end
    if (ch == CH_NUL) begin
      emit_token(KIND_END, '0, 1'b0);
      scan_state = MODE_DONE;
    end else if (ch inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR}) begin
      advance_position(ch);
    end else if (ch == CH_LBRACE) begin
      advance_position(ch);
      scan_state = MODE_COMMENT;
    end else if (is_digit(ch)) begin
      advance_position(ch);
      digit_acc = VALUE_BITS'(digit);
      digit_clamped = 1'b0;
      scan_state = MODE_NUMBER;
    end else begin
      kind = single_kind(ch);
      advance_position(ch);
      emit_token(kind, '0, 1'b0);
      if (kind == KIND_END) scan_state = MODE_DONE;
    end
  endtask

  // one byte transfer, with random idle cycles ahead of it
  task automatic feed_byte(input logic [7:0] ch);
    while (!calm && $urandom_range(99) < 12) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_char_code <= 8'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_code <= ch;
    do @(posedge clk); while (in_stall);
    step_tokens.delete();
    tokenize_char(ch);
    if (step_tokens.size() > 0) begin
      if (typed_active) begin
        step_tokens[0].tok.kind  = typed_row.kind;
        step_tokens[0].tok.value = typed_row.value;
        step_tokens[0].tok.sat   = typed_row.sat;
      end
      step_tokens[step_tokens.size()-1].last = 1'b1;
    end
    foreach (step_tokens[k]) expected_tokens.push_back(step_tokens[k]);
    typed_active = 1'b0;
    bytes_fed++;
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin : token_check
    token_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      tokens_checked++;
      if (out_token_kind <= KIND_END) kinds_seen[out_token_kind] = 1'b1;
      if (expected_tokens.size() == 0) begin
        $error("token_kind %0d arrived with no token expected", out_token_kind);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_token_kind !== want.tok.kind) begin
          $error("token_kind: expected %0d, got %0d", want.tok.kind, out_token_kind);
          fail_count++;
        end
        if (out_number_value !== want.tok.value) begin
          $error("number_value: expected %0d, got %0d", want.tok.value, out_number_value);
          fail_count++;
        end
        if (out_number_saturated !== want.tok.sat) begin
          $error("number_saturated: expected %0d, got %0d", want.tok.sat,
                 out_number_saturated);
          fail_count++;
        end
        if (out_line_number !== want.tok.line) begin
          $error("line_number: expected %0d, got %0d", want.tok.line, out_line_number);
          fail_count++;
        end
        if (out_column_number !== want.tok.col) begin
          $error("column_number: expected %0d, got %0d", want.tok.col, out_column_number);
          fail_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  // ends the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("char_stream_tokenizer_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int pick;
    int text_bytes;
    string num_text;
    logic [7:0] junk;
    logic [7:0] stray;
    close_t close_case;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[r]) begin
      typed_row = opening_rows[r];
      typed_active = opening_rows[r].typed;
      feed_byte(opening_rows[r].ch);
    end

    while (bytes_fed < ITEM_TARGET) begin
      calm = (bytes_fed >= 400 && bytes_fed < 650);
      pick = $urandom_range(99);
      if (pick < 30) begin
        feed_byte(punct_chars[$urandom_range(9)]);
      end else if (pick < 48) begin
        repeat ($urandom_range(1, 3)) feed_byte(space_chars[$urandom_range(5)]);
      end else if (pick < 72) begin
        if ($urandom_range(19) == 0) begin
          num_text = boundary_numbers[$urandom_range(3)];
          for (int i = 0; i < num_text.len(); i++) feed_byte(num_text[i]);
        end else begin
          repeat ($urandom_range(1, 4)) feed_byte(8'(CH_ZERO + $urandom_range(9)));
        end
      end else if (pick < 85) begin
        feed_byte(CH_LBRACE);
        repeat ($urandom_range(0, 6)) begin
          do junk = 8'($urandom_range(1, 255)); while (junk == CH_RBRACE);
          feed_byte(junk);
        end
        feed_byte(CH_RBRACE);
      end else begin
        // glued digits, punctuation and whitespace with no structure
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(2))
            0: feed_byte(punct_chars[$urandom_range(9)]);
            1: feed_byte(space_chars[$urandom_range(5)]);
            default: feed_byte(8'(CH_ZERO + $urandom_range(9)));
          endcase
        end
      end
    end
    calm = 1'b0;
    text_bytes = bytes_fed;

    case ($urandom_range(2))
      0: stray = 8'($urandom_range(128, 255));
      1: stray = CH_RBRACE;
      default: stray = 8'($urandom_range(8'h41, 8'h5A));
    endcase
    close_case = close_t'($urandom_range(4));
    case (close_case)
      CLOSE_NUL: feed_byte(CH_NUL);
      CLOSE_IN_COMMENT: begin
        feed_byte(CH_LBRACE);
        feed_byte(CH_NUL);
      end
      CLOSE_NUMBER_NUL: begin
        feed_byte(CH_ZERO + 8'd5);
        feed_byte(CH_NUL);
      end
      CLOSE_STRAY: feed_byte(stray);
      default: begin
        feed_byte(CH_ZERO + 8'd5);
        feed_byte(stray);
      end
    endcase

    // everything after the end token must be ignored
    repeat (TRAIL_BYTES) feed_byte(8'($urandom));
    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("scanned %0d text bytes before the closing byte, %0d tokens checked",
             text_bytes, tokens_checked);
    $display("token kinds seen %b, text closed by %s, %0d trailing bytes ignored",
             kinds_seen, close_case.name(), TRAIL_BYTES);
    if (fail_count == 0) begin
      $display("char_stream_tokenizer_top regression: pass");
    end else begin
      $display("char_stream_tokenizer_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cst_pkg.sv
rtl/cst_front.sv
rtl/cst_queue.sv
rtl/cst_back.sv
rtl/char_stream_tokenizer_top.sv
rtl/cst_checker.sv
verif/tb_top.sv
